/* hw/rtl/ccw_pkg.sv */
package ccw_pkg;

  // Sizing
  localparam int MAX_AMOUNT  = 1023;
  localparam int NUM_COINS   = 8;
  localparam int COIN_REGS   = 8;
  localparam int COIN_W      = 10;
  localparam int AMT_W       = 10;
  localparam int CNT_W       = 64;
  localparam int DEPTH       = MAX_AMOUNT + 1;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CFG_IDX_W   = 3;
  localparam int COIN_IDX_W  = 3;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = 2;

  typedef logic [COIN_REGS-1:0][COIN_W-1:0] coin_arr_t;

  // Coin register reset values, coin_a in the lowest slot
  localparam coin_arr_t COIN_RESET = {
    10'd200, 10'd100, 10'd50, 10'd20, 10'd10, 10'd5, 10'd2, 10'd1
  };

  // One table entry: sticky overflow flag over the count
  typedef struct packed {
    logic             sat;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_COIN_SEL,
    ST_SWEEP,
    ST_FIN_RD,
    ST_FIN_WAIT,
    ST_DONE
  } state_t;

  // Table port controls from the sequencer
  typedef struct packed {
    logic              we;
    logic              wr_clear;
    logic              clr_one;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } mem_ctl_t;

  // Handshake and result controls from the sequencer
  typedef struct packed {
    logic in_ready;
    logic cap;
    logic load;
    logic zero;
  } flow_t;

endpackage

/* hw/rtl/ccw_ram.sv */
module ccw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, two registered read ports (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* hw/rtl/ccw_ctrl.sv */
module ccw_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [ccw_pkg::AMT_W-1:0] in_target,
  input  ccw_pkg::coin_arr_t       coins,
  input  logic                     out_free,
  output ccw_pkg::mem_ctl_t        mem,
  output ccw_pkg::flow_t           flow
);

  ccw_pkg::state_t state, state_next;

  logic [ccw_pkg::ADDR_W-1:0]     target;
  logic [ccw_pkg::ADDR_W-1:0]     addr_a;
  logic [ccw_pkg::ADDR_W-1:0]     addr_b;
  logic [ccw_pkg::ADDR_W-1:0]     s2_addr;
  logic                           s2_valid;
  logic [ccw_pkg::COIN_IDX_W-1:0] coin_idx;
  logic                           zero;

  logic [ccw_pkg::ADDR_W-1:0] tgt_in;
  logic [ccw_pkg::COIN_W-1:0] coin_cur;
  logic                       coin_ok;
  logic                       last_coin;
  logic                       at_end;

  // Clamp the request to the table size
  always_comb begin
    if (32'(in_target) > ccw_pkg::MAX_AMOUNT) begin
      tgt_in = ccw_pkg::ADDR_W'(ccw_pkg::MAX_AMOUNT);
    end else begin
      tgt_in = ccw_pkg::ADDR_W'(in_target);
    end
  end

  assign coin_cur  = coins[coin_idx];
  assign coin_ok   = (coin_cur != '0) && (32'(coin_cur) <= 32'(target));
  assign last_coin = (coin_idx == ccw_pkg::COIN_IDX_W'(ccw_pkg::NUM_COINS - 1));
  assign at_end    = (addr_a == target);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ccw_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (tgt_in == '0) ? ccw_pkg::ST_DONE : ccw_pkg::ST_CLEAR;
        end
      end
      ccw_pkg::ST_CLEAR: begin
        if (at_end) state_next = ccw_pkg::ST_COIN_SEL;
      end
      ccw_pkg::ST_COIN_SEL: begin
        if (coin_ok) state_next = ccw_pkg::ST_SWEEP;
        else if (last_coin) state_next = ccw_pkg::ST_FIN_RD;
      end
      ccw_pkg::ST_SWEEP: begin
        if (at_end) begin
          state_next = last_coin ? ccw_pkg::ST_FIN_RD : ccw_pkg::ST_COIN_SEL;
        end
      end
      ccw_pkg::ST_FIN_RD:   state_next = ccw_pkg::ST_FIN_WAIT;
      ccw_pkg::ST_FIN_WAIT: state_next = ccw_pkg::ST_DONE;
      ccw_pkg::ST_DONE: begin
        if (out_free) state_next = ccw_pkg::ST_IDLE;
      end
      default: state_next = ccw_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    flow.in_ready = (state == ccw_pkg::ST_IDLE);
    flow.cap      = (state == ccw_pkg::ST_FIN_WAIT);
    flow.load     = (state == ccw_pkg::ST_DONE) && out_free;
    flow.zero     = zero;

    mem.wr_clear  = (state == ccw_pkg::ST_CLEAR);
    mem.we        = mem.wr_clear || s2_valid;
    mem.clr_one   = (addr_a == '0);
    mem.waddr     = mem.wr_clear ? addr_a : s2_addr;
    mem.raddr_a   = (state == ccw_pkg::ST_FIN_RD) ? target : addr_a;
    mem.raddr_b   = addr_b;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ccw_pkg::ST_IDLE;
      s2_valid <= 1'b0;
    end else begin
      state    <= state_next;
      s2_valid <= (state == ccw_pkg::ST_SWEEP);
    end
  end

  // Sweep pointers and request registers
  always_ff @(posedge clk) begin
    s2_addr <= addr_a;
    case (state)
      ccw_pkg::ST_IDLE: begin
        if (in_valid) begin
          target <= tgt_in;
          zero   <= (tgt_in == '0);
          addr_a <= '0;
        end
      end
      ccw_pkg::ST_CLEAR: begin
        addr_a <= addr_a + 1'b1;
        if (at_end) coin_idx <= '0;
      end
      ccw_pkg::ST_COIN_SEL: begin
        if (coin_ok) begin
          addr_a <= ccw_pkg::ADDR_W'(coin_cur);
          addr_b <= '0;
        end else if (!last_coin) begin
          coin_idx <= coin_idx + 1'b1;
        end
      end
      ccw_pkg::ST_SWEEP: begin
        addr_a <= addr_a + 1'b1;
        addr_b <= addr_b + 1'b1;
        if (at_end && !last_coin) coin_idx <= coin_idx + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/ccw_alu.sv */
module ccw_alu (
  input  logic              clk,
  input  logic              rst,
  input  ccw_pkg::mem_ctl_t mem,
  input  ccw_pkg::entry_t   wdata,
  input  ccw_pkg::entry_t   rdata_a,
  input  ccw_pkg::entry_t   rdata_b,
  output ccw_pkg::entry_t   x_ent,
  output ccw_pkg::entry_t   upd
);

  logic            fwd_a;
  logic            fwd_b;
  ccw_pkg::entry_t fwd_data;
  ccw_pkg::entry_t y_ent;
  logic [ccw_pkg::CNT_W:0] sum;

  // A read that hits the entry written in the same cycle takes the new word
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_a <= 1'b0;
      fwd_b <= 1'b0;
    end else begin
      fwd_a <= mem.we && (mem.waddr == mem.raddr_a);
      fwd_b <= mem.we && (mem.waddr == mem.raddr_b);
    end
    fwd_data <= wdata;
  end

  assign x_ent = fwd_a ? fwd_data : rdata_a;
  assign y_ent = fwd_b ? fwd_data : rdata_b;

  // Saturating add, overflow flag sticks with the entry
  assign sum     = {1'b0, x_ent.cnt} + {1'b0, y_ent.cnt};
  assign upd.cnt = sum[ccw_pkg::CNT_W] ? '1 : sum[ccw_pkg::CNT_W-1:0];
  assign upd.sat = x_ent.sat || y_ent.sat || sum[ccw_pkg::CNT_W];

endmodule

/* hw/rtl/coin_change_way_counter.sv */
// Counts the unordered ways to make up target_amount from the coin values in
// coin_a..coin_h, each usable any number of times; a zero coin is skipped.
// A request of zero answers 0 with zero_amount set, and a count past 2^64-1
// is clamped to all ones with saturated set. One request is worked at a
// time out of a single 1024 x 65-bit table RAM (one write, two read ports),
// one table entry per cycle: for target T > 0 the request runs a clear pass
// over entries 0..T, then a coin-select step for each coin in turn and a
// sweep over entries c..T for every coin c with 0 < c <= T, then a read of
// entry T before the result is presented on out_tvalid. A zero request skips
// the table passes. A new request is taken while the previous result still
// waits on the output. The user must write the coin registers only between
// requests; the block itself does not enforce it.
module coin_change_way_counter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ccw_pkg::IN_TDATA_W-1:0]   in_tdata,   // [9:0] target_amount
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ccw_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [63:0] way_count
  output logic [ccw_pkg::OUT_TUSER_W-1:0]  out_tuser,  // [0] zero_amount, [1] saturated
  input  logic                             cfg_we,
  input  logic [ccw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ccw_pkg::COIN_W-1:0]       cfg_data
);

  ccw_pkg::coin_arr_t coins;
  ccw_pkg::mem_ctl_t  mem;
  ccw_pkg::flow_t     flow;
  ccw_pkg::entry_t    wdata;
  ccw_pkg::entry_t    rdata_a;
  ccw_pkg::entry_t    rdata_b;
  ccw_pkg::entry_t    x_ent;
  ccw_pkg::entry_t    upd;

  logic [ccw_pkg::CNT_W-1:0] res_cnt;
  logic                      res_sat;
  logic                      out_free;

  // Coin registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coins <= ccw_pkg::COIN_RESET;
    end else if (cfg_we) begin
      coins[cfg_index] <= cfg_data;
    end
  end

  assign out_free  = !out_tvalid || out_tready;
  assign in_tready = flow.in_ready;

  ccw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_tvalid),
    .in_target (in_tdata[ccw_pkg::AMT_W-1:0]),
    .coins     (coins),
    .out_free  (out_free),
    .mem       (mem),
    .flow      (flow)
  );

  // Clear pass writes one at entry zero, zero elsewhere
  always_comb begin
    if (mem.wr_clear) begin
      wdata.sat = 1'b0;
      wdata.cnt = ccw_pkg::CNT_W'(mem.clr_one);
    end else begin
      wdata = upd;
    end
  end

  ccw_ram #(
    .WIDTH (ccw_pkg::ENTRY_W),
    .DEPTH (ccw_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (mem.we),
    .waddr   (mem.waddr),
    .wdata   (wdata),
    .raddr_a (mem.raddr_a),
    .raddr_b (mem.raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  ccw_alu u_alu (
    .clk     (clk),
    .rst     (rst),
    .mem     (mem),
    .wdata   (wdata),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b),
    .x_ent   (x_ent),
    .upd     (upd)
  );

  // Hold the final table read
  always_ff @(posedge clk) begin
    if (flow.cap) begin
      res_cnt <= x_ent.cnt;
      res_sat <= x_ent.sat;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (flow.load) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (flow.load) begin
      out_tdata    <= flow.zero ? '0 : res_cnt;
      out_tuser[0] <= flow.zero;
      out_tuser[1] <= flow.zero ? 1'b0 : res_sat;
    end
  end

endmodule

/* hw/rtl/ccw_checker.sv */
module ccw_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ccw_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [ccw_pkg::OUT_TUSER_W-1:0] out_tuser
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Zero request answers zero and never flags overflow
  a_zero_res: assert property (@(posedge clk) disable iff (rst)
    out_tvalid && out_tuser[0] |-> (out_tdata == '0) && !out_tuser[1])
    else $error("zero request gave a nonzero result");

  // An overflowed count is clamped to all ones
  a_sat_clamp: assert property (@(posedge clk) disable iff (rst)
    out_tvalid && out_tuser[1] |-> (&out_tdata))
    else $error("saturated result not clamped");

  // One request at a time: busy right after accepting
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while busy");

  // Nothing comes out of reset
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind coin_change_way_counter ccw_checker u_ccw_checker (
  .clk        (clk),
  .rst        (rst),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
